// File: src/speck32_64_block_cipher_defines.svh
// assertion macros shared by the speck checker
`ifndef SPECK32_64_BLOCK_CIPHER_DEFINES_SVH
`define SPECK32_64_BLOCK_CIPHER_DEFINES_SVH

// next-cycle implication, ignored while reset is high
`define SPK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define SPK_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/spk_pkg.sv
package spk_pkg;

   // cipher geometry
   localparam int ROUNDS  = 22;
   localparam int WORD_W  = 16;
   localparam int BLOCK_W = 2 * WORD_W;
   localparam int KEY_W   = 4 * WORD_W;
   localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   // rotation amounts of the round function
   localparam int ROT_A = 7;
   localparam int ROT_B = 2;

   // request opcodes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [RND_W-1:0]  rnd_idx_type;

   function automatic word_type rotr(input word_type v, input int n);
      rotr = (v >> n) | (v << (WORD_W - n));
   endfunction

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

endpackage

// File: src/speck32_64_block_cipher.sv
// Speck 32/64 block cipher, ECB, one shared round unit.
// csr port: csr_wr_en with csr_cipher_key loads a 64-bit key. The write
//   starts the key schedule, which runs the round unit once per round key
//   after the first, with req_ready low meanwhile.
// request channel (req_valid/req_ready): req_opcode picks encrypt or
//   decrypt, req_block_in carries {x, y}. A request is taken only while
//   the sequencer is idle.
// result channel (rsp_valid/rsp_ready): rsp_block_out carries {x, y}.
// rsp_valid rises after the last round, one round per cycle through the
//   single round unit with one round-key read, holding on the last round
//   while the output register is full. No request is taken until it is done.
// a finished block sits in the output register; the next request is
//   taken while it waits. If that register is still full when the next
//   block finishes its last round, the sequencer holds on that round until
//   rsp_ready frees it.
// reset: sequencer idle, no result pending. The round keys are undefined
//   until the first key write; requests before it give garbage.
module speck32_64_block_cipher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [spk_pkg::KEY_W-1:0]   csr_cipher_key,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [spk_pkg::BLOCK_W-1:0] req_block_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [spk_pkg::BLOCK_W-1:0] rsp_block_out
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXPAND = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;

   localparam int W = spk_pkg::WORD_W;
   localparam spk_pkg::rnd_idx_type LAST_RND   = spk_pkg::RND_W'(spk_pkg::ROUNDS - 1);
   localparam spk_pkg::rnd_idx_type LAST_EXPND = spk_pkg::RND_W'(spk_pkg::ROUNDS - 2);
   localparam logic [1:0] ST_AFTER_KEY = (spk_pkg::ROUNDS > 1) ? ST_EXPAND : ST_IDLE;

   logic [1:0]              state_ff, state_in;
   spk_pkg::rnd_idx_type    cnt_ff, cnt_in;
   logic                    op_ff, op_in;
   spk_pkg::word_type       x_ff, x_in;     // x word, or l[0] during expansion
   spk_pkg::word_type       y_ff, y_in;     // y word, or k during expansion
   spk_pkg::word_type       l1_ff, l1_in;
   spk_pkg::word_type       l2_ff, l2_in;
   spk_pkg::word_type       rk_ff [spk_pkg::ROUNDS];
   logic                    rk_we;
   spk_pkg::rnd_idx_type    rk_widx;
   spk_pkg::word_type       rk_wdata;
   spk_pkg::rnd_idx_type    rk_ridx;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [spk_pkg::BLOCK_W-1:0] rsp_block_ff, rsp_block_in;

   spk_pkg::word_type       rnd_k;
   spk_pkg::word_type       enc_x, enc_y, dec_x, dec_y;
   spk_pkg::word_type       new_x, new_y;
   logic                    out_free;
   logic                    req_fire;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid & req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;
   assign out_free      = ~rsp_valid_ff | rsp_ready;

   // round-key read address, reversed for decrypt
   assign rk_ridx = (op_ff == spk_pkg::OP_DECRYPT) ? (LAST_RND - cnt_ff) : cnt_ff;

   // key for the shared round: round index during expansion
   always_comb begin
      if (state_ff == ST_EXPAND) begin
         rnd_k = {{(W - spk_pkg::RND_W){1'b0}}, cnt_ff};
      end else begin
         rnd_k = rk_ff[rk_ridx];
      end
   end

   // shared round unit
   always_comb begin
      enc_x = (spk_pkg::rotr(x_ff, spk_pkg::ROT_A) + y_ff) ^ rnd_k;
      enc_y = spk_pkg::rotl(y_ff, spk_pkg::ROT_B) ^ enc_x;
      dec_y = spk_pkg::rotr(x_ff ^ y_ff, spk_pkg::ROT_B);
      dec_x = spk_pkg::rotl((x_ff ^ rnd_k) - dec_y, spk_pkg::ROT_A);
      if (state_ff == ST_RUN && op_ff == spk_pkg::OP_DECRYPT) begin
         new_x = dec_x;
         new_y = dec_y;
      end else begin
         new_x = enc_x;
         new_y = enc_y;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      l1_in        = l1_ff;
      l2_in        = l2_ff;
      rk_we        = 1'b0;
      rk_widx      = cnt_ff + 1'b1;
      rk_wdata     = new_y;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_block_in = rsp_block_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               op_in    = req_opcode;
               x_in     = req_block_in[spk_pkg::BLOCK_W-1:W];
               y_in     = req_block_in[W-1:0];
            end
         end
         ST_EXPAND: begin
            // k' = rol2(k) ^ t, t = (ror7(l0) + k) ^ i
            rk_we  = 1'b1;
            y_in   = new_y;
            x_in   = l1_ff;
            l1_in  = l2_ff;
            l2_in  = new_x;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_EXPND) begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (cnt_ff != LAST_RND) begin
               x_in   = new_x;
               y_in   = new_y;
               cnt_in = cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_block_in = {new_x, new_y};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // key write seeds the schedule; round key 0 is key word 0
      if (csr_wr_en) begin
         state_in = ST_AFTER_KEY;
         cnt_in   = '0;
         y_in     = csr_cipher_key[W-1:0];
         x_in     = csr_cipher_key[2*W-1:W];
         l1_in    = csr_cipher_key[3*W-1:2*W];
         l2_in    = csr_cipher_key[4*W-1:3*W];
         rk_we    = 1'b1;
         rk_widx  = '0;
         rk_wdata = csr_cipher_key[W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      l1_ff        <= l1_in;
      l2_ff        <= l2_in;
      rsp_block_ff <= rsp_block_in;
   end

   // round-key store
   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_ff[rk_widx] <= rk_wdata;
      end
   end

endmodule

// File: src/spk_checker.sv
`include "speck32_64_block_cipher_defines.svh"

module spk_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_wr_en,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [spk_pkg::BLOCK_W-1:0] rsp_block_out
);

   // a stalled result holds
   `SPK_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_block_out), "result dropped or changed under stall")

   // busy after a request is taken
   `SPK_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while rounds in progress")

   // key schedule keeps the request side closed
   `SPK_ASSERT_NEXT(a_busy_after_key, csr_wr_en, !req_ready, "request side open during key schedule")

   // nothing pending after reset
   `SPK_ASSERT_NEXT_ALL(a_reset_empty, reset, !rsp_valid, "result pending after reset")

endmodule

bind speck32_64_block_cipher spk_checker u_spk_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_wr_en     (csr_wr_en),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_block_out (rsp_block_out)
);

// File: sim/speck_block_checker.sv
`timescale 1ns / 100ps

module speck_block_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [spk_pkg::KEY_W-1:0]   csr_cipher_key,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [spk_pkg::BLOCK_W-1:0] req_block_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [spk_pkg::BLOCK_W-1:0] rsp_block_out,
   output int unsigned                 fault_count,
   output int unsigned                 blocks_in_flight
);
   import spk_pkg::*;

   typedef logic [BLOCK_W-1:0] block_type;

   word_type    sched_keys [ROUNDS];
   block_type   expected_blocks [$];
   int unsigned faults = 0;

   // fixed rotations of one cipher word
   function automatic word_type spin_right_a(input word_type v);
      return {v[ROT_A-1:0], v[WORD_W-1:ROT_A]};
   endfunction

   function automatic word_type spin_left_a(input word_type v);
      return {v[WORD_W-ROT_A-1:0], v[WORD_W-1:WORD_W-ROT_A]};
   endfunction

   function automatic word_type spin_right_b(input word_type v);
      return {v[ROT_B-1:0], v[WORD_W-1:ROT_B]};
   endfunction

   function automatic word_type spin_left_b(input word_type v);
      return {v[WORD_W-ROT_B-1:0], v[WORD_W-1:WORD_W-ROT_B]};
   endfunction

   // key schedule: word 0 is the first round key, words 1..3 seed the rest
   task automatic load_schedule(input logic [KEY_W-1:0] key);
      word_type k;
      word_type seed [3];
      word_type t;
      k       = key[WORD_W-1:0];
      seed[0] = key[2*WORD_W-1:WORD_W];
      seed[1] = key[3*WORD_W-1:2*WORD_W];
      seed[2] = key[4*WORD_W-1:3*WORD_W];
      sched_keys[0] = k;
      for (int i = 0; i < ROUNDS - 1; i++) begin
         t = (spin_right_a(seed[0]) + k) ^ word_type'(i);
         k = spin_left_b(k) ^ t;
         seed[0] = seed[1];
         seed[1] = seed[2];
         seed[2] = t;
         sched_keys[i+1] = k;
      end
   endtask

   // full block through all rounds, forward or inverse
   function automatic block_type cipher_block(input logic op, input block_type blk);
      word_type x;
      word_type y;
      x = blk[BLOCK_W-1:WORD_W];
      y = blk[WORD_W-1:0];
      if (op == OP_ENCRYPT) begin
         for (int i = 0; i < ROUNDS; i++) begin
            x = (spin_right_a(x) + y) ^ sched_keys[i];
            y = spin_left_b(y) ^ x;
         end
      end else begin
         for (int i = ROUNDS - 1; i >= 0; i--) begin
            y = spin_right_b(x ^ y);
            x = spin_left_a((x ^ sched_keys[i]) - y);
         end
      end
      return {x, y};
   endfunction

   // watch key writes, requests and results at each edge
   always @(posedge clock) begin : watch
      block_type want;
      if (reset) begin
         expected_blocks.delete();
      end else begin
         if (csr_wr_en) begin
            load_schedule(csr_cipher_key);
         end
         if (req_valid && req_ready) begin
            expected_blocks.push_back(cipher_block(req_opcode, req_block_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               faults++;
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_block_out);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_block_out !== want) begin
                  faults++;
                  $display("%0t: block_out mismatch, expected %h, actual %h",
                           $time, want, rsp_block_out);
               end
            end
         end
      end
      fault_count      <= faults;
      blocks_in_flight <= expected_blocks.size();
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import spk_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RAND_PHASES = 6;
   localparam int unsigned PHASE_ITEMS = 200;
   localparam int unsigned TAIL_ITEMS  = 100;
   localparam int unsigned SETTLE      = 30;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_wr_en      = 1'b0;
   logic [KEY_W-1:0]   csr_cipher_key = '0;
   logic               req_valid      = 1'b0;
   logic               req_opcode     = OP_ENCRYPT;
   logic [BLOCK_W-1:0] req_block_in   = '0;
   logic               rsp_ready      = 1'b0;
   wire                req_ready;
   wire                rsp_valid;
   wire  [BLOCK_W-1:0] rsp_block_out;

   int unsigned fault_count;
   int unsigned blocks_in_flight;
   int unsigned cycle_count = 0;
   int unsigned ready_hold  = 0;
   bit          send_gaps   = 1'b1;
   bit          recv_gaps   = 1'b1;

   speck32_64_block_cipher uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_cipher_key (csr_cipher_key),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_block_in   (req_block_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_block_out  (rsp_block_out)
   );

   speck_block_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_cipher_key   (csr_cipher_key),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_block_in     (req_block_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_out    (rsp_block_out),
      .fault_count      (fault_count),
      .blocks_in_flight (blocks_in_flight)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= (ready_hold == 1);
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
         ready_hold <= $urandom_range(1, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request, held until taken, then maybe a gap
   task automatic send_req(input logic op, input logic [BLOCK_W-1:0] blk);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_block_in <= blk;
      do @(posedge clock); while (!req_ready);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // stop sending and wait for every result in flight
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (blocks_in_flight != 0) @(posedge clock);
   endtask

   // key write, only while the cipher is idle
   task automatic load_key(input logic [KEY_W-1:0] key);
      csr_wr_en      <= 1'b1;
      csr_cipher_key <= key;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic both_ways(input logic [BLOCK_W-1:0] blk);
      send_req(OP_ENCRYPT, blk);
      send_req(OP_DECRYPT, blk);
   endtask

   // mostly random blocks with some corner patterns mixed in
   function automatic logic [BLOCK_W-1:0] pick_block();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return {{WORD_W{1'b0}}, WORD_W'($urandom)};
         3:       return {WORD_W'($urandom), {WORD_W{1'b1}}};
         4:       return BLOCK_W'(1) << $urandom_range(0, BLOCK_W - 1);
         default: return BLOCK_W'($urandom);
      endcase
   endfunction

   task automatic random_run(input int unsigned count);
      int unsigned pause_at;
      pause_at = $urandom_range(count / 4, 3 * count / 4);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == pause_at) begin
            drain();
         end
         send_req($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, pick_block());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // published test vector key, known pair, then corner blocks
      load_key(64'h1918_1110_0908_0100);
      send_req(OP_ENCRYPT, 32'h6574_694c);
      send_req(OP_DECRYPT, 32'ha868_42f2);
      both_ways(32'h0000_0000);
      both_ways(32'hffff_ffff);
      // wait out everything in flight before going on
      drain();
      both_ways(32'hffff_0000);
      both_ways(32'h0000_ffff);
      both_ways(32'haaaa_5555);
      both_ways(32'h0000_0001);
      both_ways(32'h8000_0000);
      drain();

      // key extremes
      load_key('0);
      both_ways(32'h0000_0000);
      both_ways(32'hffff_ffff);
      drain();
      load_key('1);
      both_ways(32'h0000_0000);
      both_ways(32'hffff_ffff);
      drain();

      // random keys and blocks, idling mixed per phase
      for (int unsigned p = 0; p < RAND_PHASES; p++) begin
         send_gaps <= ($urandom_range(0, 3) != 0);
         recv_gaps <= ($urandom_range(0, 3) != 0);
         load_key({$urandom, $urandom});
         random_run(PHASE_ITEMS);
         drain();
      end

      // last stretch at full rate on both sides
      send_gaps <= 1'b0;
      recv_gaps <= 1'b0;
      load_key({$urandom, $urandom});
      random_run(TAIL_ITEMS);
      drain();
      repeat (SETTLE) @(posedge clock);

      if (fault_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/spk_pkg.sv
src/speck32_64_block_cipher.sv
src/spk_checker.sv
sim/speck_block_checker.sv
sim/tb_top.sv
